### src/sgr_pkg.sv
// Shared types and constants of the SGR mouse report parser.
package sgr_pkg;

   // Input command codes
   localparam logic [1:0] CMD_ESCAPE = 2'd0;
   localparam logic [1:0] CMD_BYTE   = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_ENABLE        = 2'd0;
   localparam logic [1:0] CSR_FIRST_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_NEXT_TIMEOUT  = 2'd2;

   // Configuration reset values
   localparam logic       ENABLE_RST        = 1'b0;
   localparam logic [7:0] FIRST_TIMEOUT_RST = 8'd8;
   localparam logic [7:0] NEXT_TIMEOUT_RST  = 8'd4;

   localparam logic [7:0] TICK_MAX = 8'hFF;

   // Report bytes
   localparam logic [7:0] CHAR_OPEN    = 8'h5B;  // '['
   localparam logic [7:0] CHAR_LT      = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_PRESS   = 8'h4D;  // 'M'
   localparam logic [7:0] CHAR_RELEASE = 8'h6D;  // 'm'
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;  // ';'
   localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'

   // Button field bits
   localparam int BTN_MOTION_BIT = 5;
   localparam int BTN_WHEEL_BIT  = 6;

   // Width of reported cell coordinates
   localparam int REPORT_W = 16;

   // Numeric field being scanned
   localparam logic [1:0] FIELD_BUTTON = 2'd0;
   localparam logic [1:0] FIELD_COLUMN = 2'd1;
   localparam logic [1:0] FIELD_ROW    = 2'd2;
   localparam logic [1:0] FIELD_DONE   = 2'd3;

   typedef enum logic [2:0] {
      KIND_REPLAY    = 3'd0,
      KIND_NOT_MOUSE = 3'd1,
      KIND_CONSUMED  = 3'd2,
      KIND_WHEEL     = 3'd3,
      KIND_CLICK     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_OPEN,
      PH_LT,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_READ,
      ST_REPLAY,
      ST_EXTRA,
      ST_NOT_MOUSE,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SRC_MEM,
      SRC_BYTE,
      SRC_NOT_MOUSE,
      SRC_FINISH
   } emit_src_type;

   typedef struct packed {
      logic         latch_byte;
      logic         start_parse;
      logic         store_byte;
      logic         scan_byte;
      logic         tick_inc;
      logic         clr_ticks;
      logic         timeout_open;
      logic         rd_start;
      logic         rd_issue;
      logic         rd_next;
      logic         clear_len;
      logic         emit;
      emit_src_type emit_src;
      logic         emit_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic byte_open;
      logic byte_lt;
      logic byte_end;
      logic store_full;
      logic rd_done;
      logic timeout;
   } dp_status_type;

endpackage

### src/sgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sgr_datapath.sv
// Datapath: sequence store, field scanner, timeout counter, press memory, result register.
module sgr_datapath import sgr_pkg::*; #(
   parameter int SEQ_DEPTH  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_data_byte,
   input  logic [7:0]          cfg_first_timeout,
   input  logic [7:0]          cfg_next_timeout,
   input  ctl_cmd_type         cmd,
   output dp_status_type       status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [2:0]          rsp_kind,
   output logic [7:0]          rsp_replay_byte,
   output logic                rsp_wheel_down,
   output logic [REPORT_W-1:0] rsp_column,
   output logic [REPORT_W-1:0] rsp_line_row,
   output logic                rsp_last
);

   localparam int LEN_W = $clog2(SEQ_DEPTH);
   localparam int ACC_W = COORD_BITS + 4;
   localparam int EXT_W = COORD_BITS + REPORT_W;
   localparam logic [COORD_BITS-1:0] ACC_MAX = '1;

   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [7:0]            ticks_ff, ticks_in;
   logic [1:0]            field_ff, field_in;
   logic                  digit_seen_ff, digit_seen_in;
   logic                  malformed_ff, malformed_in;
   logic [COORD_BITS-1:0] button_ff, button_in;
   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [7:0]            suffix_ff, suffix_in;
   logic                  press_active_ff, press_active_in;
   logic [COORD_BITS-1:0] press_column_ff, press_column_in;
   logic [COORD_BITS-1:0] press_row_ff, press_row_in;
   logic [7:0]            byte_ff, byte_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic                  rsp_wd_ff, rsp_wd_in;
   logic [REPORT_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [REPORT_W-1:0]   rsp_row_ff, rsp_row_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [7:0]            ram_rd_data;
   logic [7:0]            ticks_inc;
   logic [7:0]            limit;
   logic                  is_digit;
   logic [3:0]            digit;
   logic [COORD_BITS-1:0] acc_sel;
   logic [ACC_W-1:0]      acc_ext;
   logic [ACC_W-1:0]      acc_prod;
   logic [COORD_BITS-1:0] acc_next;

   kind_type              fin_kind;
   logic                  fin_set_press;
   logic                  fin_clr_press;
   logic                  well_formed;
   logic                  other_button;
   logic                  same_cell;
   logic [EXT_W-1:0]      col_ext;
   logic [EXT_W-1:0]      row_ext;

   sgr_ram #(
      .WIDTH (8),
      .DEPTH (SEQ_DEPTH)
   ) u_seq_ram (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (len_ff),
      .wr_data (req_data_byte),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   // timeout compare
   always_comb begin
      ticks_inc = (ticks_ff == TICK_MAX) ? TICK_MAX : ticks_ff + 8'd1;
      limit     = cmd.timeout_open ? cfg_first_timeout : cfg_next_timeout;
   end

   // one decimal digit step: acc * 10 + d, saturated
   always_comb begin
      is_digit = (req_data_byte >= CHAR_ZERO) && (req_data_byte <= CHAR_NINE);
      digit    = 4'(req_data_byte - CHAR_ZERO);
      unique case (field_ff)
         FIELD_BUTTON: acc_sel = button_ff;
         FIELD_COLUMN: acc_sel = column_ff;
         default:      acc_sel = row_ff;
      endcase
      acc_ext  = ACC_W'(acc_sel);
      acc_prod = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(digit);
      acc_next = (acc_prod > ACC_W'(ACC_MAX)) ? ACC_MAX : acc_prod[COORD_BITS-1:0];
   end

   // report decode from the scanned fields
   always_comb begin
      well_formed   = !malformed_ff && (field_ff == FIELD_DONE);
      other_button  = (button_ff[1:0] != 2'd0) || button_ff[BTN_MOTION_BIT]
                      || button_ff[BTN_WHEEL_BIT];
      same_cell     = (press_column_ff == column_ff) && (press_row_ff == row_ff);
      fin_kind      = KIND_CONSUMED;
      fin_set_press = 1'b0;
      fin_clr_press = 1'b0;
      priority if (!well_formed) begin
         fin_kind = KIND_CONSUMED;
      end else if (suffix_ff == CHAR_PRESS && button_ff[BTN_WHEEL_BIT]
                   && !button_ff[BTN_MOTION_BIT]) begin
         fin_kind = KIND_WHEEL;
      end else if (other_button) begin
         fin_kind = KIND_CONSUMED;
      end else if (suffix_ff == CHAR_PRESS) begin
         fin_set_press = 1'b1;
      end else if (suffix_ff == CHAR_RELEASE && press_active_ff) begin
         fin_clr_press = 1'b1;
         if (same_cell) begin
            fin_kind = KIND_CLICK;
         end
      end else begin
         fin_kind = KIND_CONSUMED;
      end
      col_ext = EXT_W'(column_ff);
      row_ext = EXT_W'(row_ff);
   end

   always_comb begin
      len_in          = len_ff;
      rd_idx_in       = rd_idx_ff;
      ticks_in        = ticks_ff;
      field_in        = field_ff;
      digit_seen_in   = digit_seen_ff;
      malformed_in    = malformed_ff;
      button_in       = button_ff;
      column_in       = column_ff;
      row_in          = row_ff;
      suffix_in       = suffix_ff;
      press_active_in = press_active_ff;
      press_column_in = press_column_ff;
      press_row_in    = press_row_ff;
      byte_in         = cmd.latch_byte ? req_data_byte : byte_ff;

      if (cmd.clear_len) begin
         len_in = '0;
      end else if (cmd.store_byte) begin
         len_in = len_ff + LEN_W'(1);
      end

      if (cmd.rd_start) begin
         rd_idx_in = '0;
      end else if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff + LEN_W'(1);
      end

      if (cmd.start_parse || cmd.clr_ticks || cmd.clear_len) begin
         ticks_in = '0;
      end else if (cmd.tick_inc) begin
         ticks_in = ticks_inc;
      end

      if (cmd.start_parse) begin
         field_in      = FIELD_BUTTON;
         digit_seen_in = 1'b0;
         malformed_in  = 1'b0;
         button_in     = '0;
         column_in     = '0;
         row_in        = '0;
         suffix_in     = '0;
      end else if (cmd.scan_byte && !malformed_ff && field_ff != FIELD_DONE) begin
         priority if (is_digit) begin
            unique case (field_ff)
               FIELD_BUTTON: button_in = acc_next;
               FIELD_COLUMN: column_in = acc_next;
               default:      row_in    = acc_next;
            endcase
            digit_seen_in = 1'b1;
         end else if (!digit_seen_ff) begin
            malformed_in = 1'b1;
         end else if (field_ff != FIELD_ROW && req_data_byte == CHAR_SEMI) begin
            field_in      = field_ff + 2'd1;
            digit_seen_in = 1'b0;
         end else if (field_ff == FIELD_ROW) begin
            suffix_in = req_data_byte;
            field_in  = FIELD_DONE;
         end else begin
            malformed_in = 1'b1;
         end
      end

      if (cmd.emit && cmd.emit_src == SRC_FINISH) begin
         if (fin_set_press) begin
            press_active_in = 1'b1;
            press_column_in = column_ff;
            press_row_in    = row_ff;
         end else if (fin_clr_press) begin
            press_active_in = 1'b0;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_wd_in    = rsp_wd_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.emit_last;
         rsp_byte_in  = '0;
         rsp_wd_in    = 1'b0;
         rsp_col_in   = '0;
         rsp_row_in   = '0;
         unique case (cmd.emit_src)
            SRC_MEM: begin
               rsp_kind_in = KIND_REPLAY;
               rsp_byte_in = ram_rd_data;
            end
            SRC_BYTE: begin
               rsp_kind_in = KIND_REPLAY;
               rsp_byte_in = byte_ff;
            end
            SRC_NOT_MOUSE: begin
               rsp_kind_in = KIND_NOT_MOUSE;
            end
            SRC_FINISH: begin
               rsp_kind_in = fin_kind;
               if (fin_kind == KIND_WHEEL || fin_kind == KIND_CLICK) begin
                  rsp_col_in = col_ext[REPORT_W-1:0];
                  rsp_row_in = row_ext[REPORT_W-1:0];
               end
               if (fin_kind == KIND_WHEEL) begin
                  rsp_wd_in = button_ff[0];
               end
            end
            default: rsp_kind_in = KIND_CONSUMED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff          <= '0;
         rd_idx_ff       <= '0;
         ticks_ff        <= '0;
         field_ff        <= FIELD_BUTTON;
         digit_seen_ff   <= 1'b0;
         malformed_ff    <= 1'b0;
         button_ff       <= '0;
         column_ff       <= '0;
         row_ff          <= '0;
         suffix_ff       <= '0;
         press_active_ff <= 1'b0;
         press_column_ff <= '0;
         press_row_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         len_ff          <= len_in;
         rd_idx_ff       <= rd_idx_in;
         ticks_ff        <= ticks_in;
         field_ff        <= field_in;
         digit_seen_ff   <= digit_seen_in;
         malformed_ff    <= malformed_in;
         button_ff       <= button_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
         suffix_ff       <= suffix_in;
         press_active_ff <= press_active_in;
         press_column_ff <= press_column_in;
         press_row_ff    <= press_row_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      byte_ff     <= byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_wd_ff   <= rsp_wd_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.byte_open  = (req_data_byte == CHAR_OPEN);
      status.byte_lt    = (req_data_byte == CHAR_LT);
      status.byte_end   = (req_data_byte == CHAR_PRESS) || (req_data_byte == CHAR_RELEASE);
      status.store_full = (len_ff == LEN_W'(SEQ_DEPTH - 2));
      status.rd_done    = (rd_idx_ff == len_ff);
      status.timeout    = (ticks_inc >= limit);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_replay_byte = rsp_byte_ff;
   assign rsp_wheel_down  = rsp_wd_ff;
   assign rsp_column      = rsp_col_ff;
   assign rsp_line_row    = rsp_row_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### src/sgr_ctrl.sv
// Controller: parse phase and result sequencing state machine.
module sgr_ctrl import sgr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_command,
   input  logic          cfg_enable,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic           extra_ff, extra_in;     // replay the latched byte after stored ones
   logic [1:0]     nm_cnt_ff, nm_cnt_in;   // not-mouse results still owed

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      extra_in  = extra_ff;
      nm_cnt_in = nm_cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_ACCEPT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_byte = 1'b1;
               cmd.rd_start   = 1'b1;
               extra_in       = 1'b0;
               nm_cnt_in      = 2'd0;
               unique case (req_command)
                  CMD_ESCAPE: begin
                     // abandon a running parse, then restart or refuse
                     cmd.start_parse = 1'b1;
                     nm_cnt_in = 2'(phase_ff != PH_IDLE) + 2'(!cfg_enable);
                     phase_in  = cfg_enable ? PH_OPEN : PH_IDLE;
                     if (phase_ff != PH_IDLE || !cfg_enable) begin
                        state_in = ST_READ;
                     end
                  end
                  CMD_BYTE: begin
                     cmd.clr_ticks = 1'b1;
                     unique case (phase_ff)
                        PH_IDLE: begin
                           extra_in = 1'b1;
                           state_in = ST_READ;
                        end
                        PH_OPEN: begin
                           if (status.byte_open) begin
                              cmd.store_byte = 1'b1;
                              phase_in       = PH_LT;
                           end else begin
                              extra_in  = 1'b1;
                              nm_cnt_in = 2'd1;
                              phase_in  = PH_IDLE;
                              state_in  = ST_READ;
                           end
                        end
                        PH_LT: begin
                           if (status.byte_lt) begin
                              cmd.store_byte = 1'b1;
                              phase_in       = PH_BODY;
                           end else begin
                              extra_in  = 1'b1;
                              nm_cnt_in = 2'd1;
                              phase_in  = PH_IDLE;
                              state_in  = ST_READ;
                           end
                        end
                        PH_BODY: begin
                           cmd.store_byte = 1'b1;
                           cmd.scan_byte  = 1'b1;
                           if (status.byte_end) begin
                              phase_in = PH_IDLE;
                              state_in = ST_FINISH;
                           end else if (status.store_full) begin
                              nm_cnt_in = 2'd1;
                              phase_in  = PH_IDLE;
                              state_in  = ST_READ;
                           end
                        end
                        default: phase_in = PH_IDLE;
                     endcase
                  end
                  CMD_TICK: begin
                     cmd.timeout_open = (phase_ff == PH_OPEN);
                     if (phase_ff != PH_IDLE) begin
                        if (status.timeout) begin
                           nm_cnt_in = 2'd1;
                           phase_in  = PH_IDLE;
                           state_in  = ST_READ;
                        end else begin
                           cmd.tick_inc = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (status.rd_done) begin
               if (extra_ff) begin
                  state_in = ST_EXTRA;
               end else if (nm_cnt_ff != 2'd0) begin
                  state_in = ST_NOT_MOUSE;
               end else begin
                  cmd.clear_len = 1'b1;
                  state_in      = ST_ACCEPT;
               end
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_REPLAY;
            end
         end
         ST_REPLAY: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_src = SRC_MEM;
               cmd.rd_next  = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_EXTRA: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_BYTE;
               cmd.emit_last = (nm_cnt_ff == 2'd0);
               if (nm_cnt_ff == 2'd0) begin
                  cmd.clear_len = 1'b1;
                  state_in      = ST_ACCEPT;
               end else begin
                  state_in = ST_NOT_MOUSE;
               end
            end
         end
         ST_NOT_MOUSE: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_NOT_MOUSE;
               cmd.emit_last = (nm_cnt_ff == 2'd1);
               nm_cnt_in     = nm_cnt_ff - 2'd1;
               if (nm_cnt_ff == 2'd1) begin
                  cmd.clear_len = 1'b1;
                  state_in      = ST_ACCEPT;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_FINISH;
               cmd.emit_last = 1'b1;
               cmd.clear_len = 1'b1;
               state_in      = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_ACCEPT;
         phase_ff  <= PH_IDLE;
         extra_ff  <= 1'b0;
         nm_cnt_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         extra_ff  <= extra_in;
         nm_cnt_ff <= nm_cnt_in;
      end
   end

endmodule

### src/sgr_mouse_report_parser.sv
// Top level of the SGR mouse report parser: CSR bank, controller and datapath.
//
// Use: after the receiver sees ESC it sends an escape transaction
// (req_command = escape), then each following terminal byte as a data
// transaction and one tick transaction per millisecond. The block recognizes
// "[<button;col;row" ended by 'M' or 'm' and answers on the rsp channel with
// replayed bytes, not-mouse, consumed, wheel or left click transactions;
// rsp_last marks the final transaction caused by one request.
// Tick and in-sequence byte transactions with no result leave req_ready high.
// A request with results holds req_ready low until its last result is loaded
// into the rsp register. When a sequence is abandoned, each stored byte is
// read from the RAM and then emitted, one byte at a time through the single
// RAM read port. A finished report's result is loaded from the finish state;
// any other request passes the read state first, then a replay, extra-byte or
// not-mouse state loads its first result.
// Stalls: rsp_ready low freezes the rsp register; the sequencer waits on it.
// csr transactions are always taken (csr_ready high) and are meant for an
// idle block. Reset clears the CSRs to defaults (disabled, 8 and 4 ticks),
// the parse phase, the pending press and the rsp valid flag. The sequence RAM
// is not cleared: only entries written in the current parse are read.
module sgr_mouse_report_parser import sgr_pkg::*; #(
   parameter int SEQ_DEPTH  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic [7:0]          req_data_byte,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_kind,
   output logic [7:0]          rsp_replay_byte,
   output logic                rsp_wheel_down,
   output logic [REPORT_W-1:0] rsp_column,
   output logic [REPORT_W-1:0] rsp_line_row,
   output logic                rsp_last,
   // configuration write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data
);

   // CSR bank
   logic          enable_ff, enable_in;
   logic [7:0]    first_to_ff, first_to_in;
   logic [7:0]    next_to_ff, next_to_in;

   ctl_cmd_type   cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      enable_in   = enable_ff;
      first_to_in = first_to_ff;
      next_to_in  = next_to_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:        enable_in   = csr_data[0];
            CSR_FIRST_TIMEOUT: first_to_in = csr_data;
            CSR_NEXT_TIMEOUT:  next_to_in  = csr_data;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= ENABLE_RST;
         first_to_ff <= FIRST_TIMEOUT_RST;
         next_to_ff  <= NEXT_TIMEOUT_RST;
      end else begin
         enable_ff   <= enable_in;
         first_to_ff <= first_to_in;
         next_to_ff  <= next_to_in;
      end
   end

   // Controller: parse phase plus replay / not-mouse / finish sequencing
   sgr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .cfg_enable  (enable_ff),
      .status      (status),
      .cmd         (cmd)
   );

   // Datapath: byte store, decimal scanner, tick counter, rsp register
   sgr_datapath #(
      .SEQ_DEPTH  (SEQ_DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_data_byte     (req_data_byte),
      .cfg_first_timeout (first_to_ff),
      .cfg_next_timeout  (next_to_ff),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_replay_byte   (rsp_replay_byte),
      .rsp_wheel_down    (rsp_wheel_down),
      .rsp_column        (rsp_column),
      .rsp_line_row      (rsp_line_row),
      .rsp_last          (rsp_last)
   );

endmodule

### src/sgr_checker.sv
// Port-level checks of the SGR mouse report parser, bound to the top level.
module sgr_checker import sgr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [2:0]          rsp_kind,
   input logic [7:0]          rsp_replay_byte,
   input logic                rsp_wheel_down,
   input logic [REPORT_W-1:0] rsp_column,
   input logic [REPORT_W-1:0] rsp_line_row,
   input logic                rsp_last
);

   // nothing is offered in the cycle after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_replay_byte) && $stable(rsp_wheel_down)
         && $stable(rsp_column) && $stable(rsp_line_row) && $stable(rsp_last))
      else $error("stalled rsp transaction changed");

   // only replay transactions carry a byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_REPLAY |-> rsp_replay_byte == 8'd0)
      else $error("replay byte set on a non-replay transaction");

   // cell only on wheel or click
   a_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_WHEEL && rsp_kind != KIND_CLICK
         |-> rsp_column == '0 && rsp_line_row == '0)
      else $error("cell set on a transaction without a mouse event");

   // wheel direction only on wheel
   a_wheel_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wheel_down |-> rsp_kind == KIND_WHEEL)
      else $error("wheel_down set on a non-wheel transaction");

endmodule

bind sgr_mouse_report_parser sgr_checker u_sgr_checker (.*);
